// File: design/brc_pkg.sv
// ----------------------------------------------------------------------------
// brc_pkg
// Shared types and constants of the byte rotor cipher: symbol width, request
// kinds, the pipeline slot record and the reflector function.
// ----------------------------------------------------------------------------
package brc_pkg;

    localparam int ALPHABET_SIZE = 256;
    localparam int SYM_W         = 8;
    localparam int HALF_SIZE     = ALPHABET_SIZE / 2;

    typedef logic [SYM_W-1:0] sym_t;

    localparam logic [1:0] KIND_CIPHER  = 2'd0;
    localparam logic [1:0] KIND_LOAD    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // How a lookup stage conditions the value it receives from the stage before.
    localparam logic [1:0] XF_NONE    = 2'd0;
    localparam logic [1:0] XF_REFLECT = 2'd1;
    localparam logic [1:0] XF_SUB     = 2'd2;

    localparam sym_t SYM_MAX = sym_t'(ALPHABET_SIZE - 1);

    typedef struct packed {
        logic       valid;
        logic       is_load;
        logic [1:0] sel;
        sym_t       pos;
        sym_t       tgt;
        sym_t       x;
    } slot_t;

    // The reflector swaps the two halves of the alphabet.
    function automatic sym_t reflect_sym(input sym_t x);
        return x ^ sym_t'(HALF_SIZE);
    endfunction

endpackage

// File: design/brc_cmd_if.sv
// ----------------------------------------------------------------------------
// brc_cmd_if
// Request channel of the byte rotor cipher: cipher, wiring load and restart.
// ----------------------------------------------------------------------------
interface brc_cmd_if import brc_pkg::*;;

    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [1:0] rotor_sel;
    sym_t       wire_position;
    sym_t       wire_target;
    sym_t       data_byte;

    modport source (
        output valid, kind, rotor_sel, wire_position, wire_target, data_byte,
        input  ready
    );

    modport sink (
        input  valid, kind, rotor_sel, wire_position, wire_target, data_byte,
        output ready
    );

endinterface

// File: design/brc_rsp_if.sv
// ----------------------------------------------------------------------------
// brc_rsp_if
// Result channel of the byte rotor cipher: one transformed byte per cipher
// request.
// ----------------------------------------------------------------------------
interface brc_rsp_if import brc_pkg::*;;

    logic valid;
    logic ready;
    sym_t out_byte;

    modport source (
        output valid, out_byte,
        input  ready
    );

    modport sink (
        input  valid, out_byte,
        output ready
    );

endinterface

// File: design/brc_stage.sv
// ----------------------------------------------------------------------------
// brc_stage
// One lookup stage: a 256-entry wiring memory of one rotor, forward or
// inverse, with its slot register. Loads write the memory as they pass.
// ----------------------------------------------------------------------------
module brc_stage import brc_pkg::*; #(
    parameter int         ROTOR       = 0,
    parameter bit         FORWARD     = 1'b1,
    parameter int         ROTOR_COUNT = 3,
    parameter logic [1:0] XFORM       = XF_NONE,
    parameter int         SUB_ROTOR   = 0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  slot_t                            slot_in,
    input  logic [ROTOR_COUNT-1:0][SYM_W-1:0] offs_in,
    output slot_t                            slot_out,
    output logic [ROTOR_COUNT-1:0][SYM_W-1:0] offs_out
);

    sym_t  mem [ALPHABET_SIZE];

    sym_t  x_in;
    sym_t  rd_addr;
    sym_t  wr_addr;
    sym_t  wr_data;
    logic  wr_en;

    logic  valid_reg;
    slot_t slot_reg;
    sym_t  rd_data_reg;
    logic [ROTOR_COUNT-1:0][SYM_W-1:0] offs_reg;

    always_comb
    begin
        case (XFORM)
            XF_REFLECT: x_in = reflect_sym(slot_in.x);
            XF_SUB:     x_in = slot_in.x - offs_in[SUB_ROTOR];
            default:    x_in = slot_in.x;
        endcase
        rd_addr = FORWARD ? sym_t'(x_in + offs_in[ROTOR]) : x_in;
    end

    // The forward table is indexed by position, the inverse one by target.
    assign wr_en   = en && slot_in.valid && slot_in.is_load && (int'(slot_in.sel) == ROTOR);
    assign wr_addr = FORWARD ? slot_in.pos : slot_in.tgt;
    assign wr_data = FORWARD ? slot_in.tgt : slot_in.pos;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= slot_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            slot_reg <= slot_in;
            offs_reg <= offs_in;
        end
    end

    always_comb
    begin
        slot_out       = slot_reg;
        slot_out.valid = valid_reg;
        slot_out.x     = rd_data_reg;
    end

    assign offs_out = offs_reg;

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(rd_data_reg) && $stable(valid_reg))
        else $error("lookup stage changed while the pipeline was stalled");

endmodule

// File: design/brc_odometer.sv
// ----------------------------------------------------------------------------
// brc_odometer
// Rotor offset counter: rotor 0 steps on every cipher request, each rotor
// carries into the next when it wraps, and a restart clears all offsets.
// ----------------------------------------------------------------------------
module brc_odometer import brc_pkg::*; #(
    parameter int ROTOR_COUNT = 3
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic                             restart,
    output logic [ROTOR_COUNT-1:0][SYM_W-1:0] offs
);

    logic [ROTOR_COUNT-1:0][SYM_W-1:0] offs_reg;
    logic [ROTOR_COUNT-1:0][SYM_W-1:0] offs_next;
    logic                              carry;

    always_comb
    begin
        carry = 1'b1;
        for (int r = 0; r < ROTOR_COUNT; r++)
        begin
            offs_next[r] = offs_reg[r] + sym_t'(carry);
            carry        = carry & (offs_reg[r] == SYM_MAX);
        end
        if (restart)
        begin
            offs_next = '0;
        end
        else if (!step)
        begin
            offs_next = offs_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offs_reg <= '0;
        end
        else
        begin
            offs_reg <= offs_next;
        end
    end

    assign offs = offs_reg;

    a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> (offs_reg == '0))
        else $error("rotor offsets not cleared by restart");

    a_first_steps: assert property (@(posedge clk) disable iff (!rst_n)
        step && !restart |=> (offs_reg[0] == sym_t'($past(offs_reg[0]) + 1'b1)))
        else $error("first rotor did not advance on a cipher request");

endmodule

// File: design/byte_rotor_cipher_core.sv
// ----------------------------------------------------------------------------
// byte_rotor_cipher_core
// Byte-wide rotor cipher with loadable rotor wirings and a fixed reflector.
// ----------------------------------------------------------------------------
// Requests arrive on cmd. A cipher request (kind 0) yields one byte on rsp; a
// wiring load (kind 1) writes the forward and inverse tables of one rotor; a
// restart (kind 2) zeroes the rotor offsets. Loads and restarts give no result.
// Each rotor keeps two 256-entry memories, and every request walks a pipeline
// of 2*ROTOR_COUNT lookup stages, one memory read per stage, forward through
// the rotors, across the reflector and back. Loads travel the same pipeline and
// write each table at the stage that reads it, so every table sees requests in
// order and needs no forwarding.
// Throughput is one request per cycle while rsp is not stalled. A request is
// registered in the entry slot, each lookup stage and the output register.
// Rotor offsets are taken at acceptance and stepped then, so successive bytes
// never wait on each other.
// Reset clears the offsets and the pipeline; wiring is undefined until loaded.
// When rsp stalls, the whole pipeline holds and cmd.ready drops until the
// output register is taken.
// ----------------------------------------------------------------------------
module byte_rotor_cipher_core import brc_pkg::*; #(
    parameter int ROTOR_COUNT = 3
) (
    input  logic          clk,
    input  logic          rst_n,
    brc_cmd_if.sink       cmd,
    brc_rsp_if.source     rsp
);

    localparam int STAGES = 2 * ROTOR_COUNT;

    typedef logic [ROTOR_COUNT-1:0][SYM_W-1:0] offs_t;

    logic  en;
    logic  accept;
    logic  step;
    logic  restart;
    offs_t offs_cur;

    slot_t slot0_reg;
    logic  slot0_valid_reg;
    offs_t offs0_reg;
    slot_t slot0;

    slot_t slots     [STAGES+1];
    offs_t offs_chain[STAGES+1];

    logic  out_valid_reg;
    sym_t  out_byte_reg;
    slot_t last;
    offs_t last_offs;

    assign en       = !out_valid_reg || rsp.ready;
    assign cmd.ready = en;
    assign accept   = cmd.valid && en;
    assign step     = accept && (cmd.kind == KIND_CIPHER);
    assign restart  = accept && (cmd.kind == KIND_RESTART);

    brc_odometer #(
        .ROTOR_COUNT(ROTOR_COUNT)
    ) u_odometer (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .restart(restart),
        .offs   (offs_cur)
    );

    // Entry slot: only cipher and load requests enter the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            slot0_valid_reg <= accept &&
                ((cmd.kind == KIND_CIPHER) || (cmd.kind == KIND_LOAD));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            slot0_reg.valid   <= 1'b0;
            slot0_reg.is_load <= (cmd.kind == KIND_LOAD);
            slot0_reg.sel     <= cmd.rotor_sel;
            slot0_reg.pos     <= cmd.wire_position;
            slot0_reg.tgt     <= cmd.wire_target;
            slot0_reg.x       <= cmd.data_byte;
            offs0_reg         <= offs_cur;
        end
    end

    always_comb
    begin
        slot0       = slot0_reg;
        slot0.valid = slot0_valid_reg;
    end

    assign slots[0]      = slot0;
    assign offs_chain[0] = offs0_reg;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam bit         FWD  = (i < ROTOR_COUNT);
        localparam int         ROT  = FWD ? i : (STAGES - 1 - i);
        localparam logic [1:0] XF   = (i == ROTOR_COUNT) ? XF_REFLECT :
                                      (i > ROTOR_COUNT)  ? XF_SUB : XF_NONE;
        localparam int         SUBR = (i > ROTOR_COUNT) ? (STAGES - i) : 0;

        brc_stage #(
            .ROTOR      (ROT),
            .FORWARD    (FWD),
            .ROTOR_COUNT(ROTOR_COUNT),
            .XFORM      (XF),
            .SUB_ROTOR  (SUBR)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .slot_in (slots[i]),
            .offs_in (offs_chain[i]),
            .slot_out(slots[i+1]),
            .offs_out(offs_chain[i+1])
        );
    end

    assign last      = slots[STAGES];
    assign last_offs = offs_chain[STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= last.valid && !last.is_load;
        end
    end

    // The last inverse lookup still owes the subtraction of rotor 0's offset.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_byte_reg <= last.x - last_offs[0];
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.out_byte = out_byte_reg;

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(last.valid && !last.is_load))
        else $error("result produced without a cipher request at the pipeline end");

    a_entry_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(slot0_valid_reg) && $stable(out_valid_reg))
        else $error("pipeline moved while the result was stalled");

endmodule
